/* rtl/rhm_pkg.sv */
// ----------------------------------------------------------------------------
// rhm_pkg
// Shared types and constants of the RGB histogram matching block.
// ----------------------------------------------------------------------------
package rhm_pkg;

   localparam int COUNT_BITS_DEFAULT      = 24;
   localparam int BLEND_FRAC_BITS_DEFAULT = 8;
   localparam int BINS                    = 256;
   localparam int PIX_BITS                = 8;
   localparam int BLEND_REG_BITS          = 9;
   localparam logic [BLEND_REG_BITS-1:0] BLEND_RESET = 9'd256;

   localparam logic [2:0] CMD_CLEAR_REF = 3'd0;
   localparam logic [2:0] CMD_ADD_REF   = 3'd1;
   localparam logic [2:0] CMD_ADD_SRC   = 3'd2;
   localparam logic [2:0] CMD_BUILD     = 3'd3;
   localparam logic [2:0] CMD_MAP       = 3'd4;

   typedef struct packed {
      logic [2:0]          command;
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] red_out;
      logic [PIX_BITS-1:0] green_out;
      logic [PIX_BITS-1:0] blue_out;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_CLR_ALL,
      OP_CLR_REF,
      OP_READ,
      OP_INC_REF,
      OP_INC_SRC,
      OP_BUILD
   } chan_op_type;

   typedef struct packed {
      chan_op_type         op;
      logic [PIX_BITS-1:0] addr;
   } chan_ctl_type;

   typedef struct packed {
      logic                build_done;
      logic [PIX_BITS-1:0] tbl_val;
   } chan_sts_type;

endpackage

/* rtl/rgb_histogram_matching.sv */
// ----------------------------------------------------------------------------
// rgb_histogram_matching
// Per-channel RGB histogram matching with a blend control.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken when start is high and busy is low. Clear reference
// empties the reference histograms. Add reference and add source pixel
// requests each do a read, then an increment write-back in the per-channel
// bin memories. Build map walks the cumulative counts of each channel with
// two pointers, all three channels in parallel; every pointer step is a
// memory read, accumulate, multiply and compare. A build also clears the
// source histograms and count. A map pixel request returns its result on
// rsp_data with rsp_valid high for one cycle; the next request can be taken
// in the cycle that the result appears. Other requests give no result. The
// receiver cannot stall the block, so results are never held. After reset,
// busy stays high while all bin and table memories are cleared; blend_factor
// can be written at any idle time through csr_wr_en and csr_wr_data and
// resets to fully mapped.
module rgb_histogram_matching import rhm_pkg::*; #(
   parameter int COUNT_BITS      = COUNT_BITS_DEFAULT,
   parameter int BLEND_FRAC_BITS = BLEND_FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [BLEND_REG_BITS-1:0] csr_wr_data
);

   // Blend arithmetic width: wide enough for the register and for 2^frac.
   localparam int BW = (BLEND_FRAC_BITS + 1 > BLEND_REG_BITS) ?
                       BLEND_FRAC_BITS + 1 : BLEND_REG_BITS;
   localparam int MW = BW + PIX_BITS + 1;
   localparam logic [BW-1:0] BLEND_ONE = BW'(1) << BLEND_FRAC_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PIX_BITS-1:0] LAST = {PIX_BITS{1'b1}};

   typedef enum logic [3:0] {
      ST_CLR_ALL, ST_IDLE, ST_CLR_REF, ST_ADD_RD, ST_ADD_WR,
      ST_BLD_GO, ST_BLD_WAIT, ST_MAP_RD, ST_MAP_OUT
   } state_type;

   state_type                 state_ff, state_in;
   logic [PIX_BITS-1:0]       sweep_ff, sweep_in;
   req_type                   req_ff, req_in;
   logic [COUNT_BITS-1:0]     ref_total_ff, ref_total_in, src_total_ff, src_total_in;
   logic [BLEND_REG_BITS-1:0] blend_ff, blend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   chan_op_type  op;
   chan_ctl_type ctl_r, ctl_g, ctl_b;
   chan_sts_type sts_r, sts_g, sts_b;
   logic [BW-1:0] blend_w;
   logic          accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Effective blend weight, clamped to one.
   assign blend_w = (BW'(blend_ff) > BLEND_ONE) ? BLEND_ONE : BW'(blend_ff);

   function automatic logic [PIX_BITS-1:0] blend(input logic [BW-1:0] b,
                                                 input logic [PIX_BITS-1:0] t,
                                                 input logic [PIX_BITS-1:0] x);
      logic [MW-1:0] mix;
      mix = MW'(b) * MW'(t) + MW'(BLEND_ONE - b) * MW'(x);
      return mix[BLEND_FRAC_BITS +: PIX_BITS];
   endfunction

   // Channel operation follows the controller state.
   always_comb begin
      unique case (state_ff)
         ST_CLR_ALL: op = OP_CLR_ALL;
         ST_CLR_REF: op = OP_CLR_REF;
         ST_ADD_RD,
         ST_MAP_RD:  op = OP_READ;
         ST_ADD_WR:  op = (req_ff.command == CMD_ADD_REF) ? OP_INC_REF : OP_INC_SRC;
         ST_BLD_GO:  op = OP_BUILD;
         default:    op = OP_IDLE;
      endcase
   end

   // Clearing sweeps address every bin; everything else uses the pixel value.
   always_comb begin
      ctl_r.op = op;
      ctl_g.op = op;
      ctl_b.op = op;
      if (state_ff == ST_CLR_ALL || state_ff == ST_CLR_REF) begin
         ctl_r.addr = sweep_ff;
         ctl_g.addr = sweep_ff;
         ctl_b.addr = sweep_ff;
      end else begin
         ctl_r.addr = req_ff.red;
         ctl_g.addr = req_ff.green;
         ctl_b.addr = req_ff.blue;
      end
   end

   rhm_chan #(.COUNT_BITS(COUNT_BITS)) u_chan_r (
      .clock(clock), .reset(reset), .ctl(ctl_r),
      .ref_total(ref_total_ff), .src_total(src_total_ff), .sts(sts_r));
   rhm_chan #(.COUNT_BITS(COUNT_BITS)) u_chan_g (
      .clock(clock), .reset(reset), .ctl(ctl_g),
      .ref_total(ref_total_ff), .src_total(src_total_ff), .sts(sts_g));
   rhm_chan #(.COUNT_BITS(COUNT_BITS)) u_chan_b (
      .clock(clock), .reset(reset), .ctl(ctl_b),
      .ref_total(ref_total_ff), .src_total(src_total_ff), .sts(sts_b));

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      req_in       = req_ff;
      ref_total_in = ref_total_ff;
      src_total_in = src_total_ff;
      blend_in     = csr_wr_en ? csr_wr_data : blend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_CLR_ALL: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST) state_in = ST_IDLE;
         end
         ST_IDLE: if (accept) begin
            req_in   = req_data;
            sweep_in = '0;
            case (req_data.command)
               CMD_CLEAR_REF: begin
                  state_in     = ST_CLR_REF;
                  ref_total_in = '0;
               end
               CMD_ADD_REF, CMD_ADD_SRC: state_in = ST_ADD_RD;
               CMD_BUILD:                state_in = ST_BLD_GO;
               CMD_MAP:                  state_in = ST_MAP_RD;
               default:                  state_in = ST_IDLE;
            endcase
         end
         ST_CLR_REF: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST) state_in = ST_IDLE;
         end
         ST_ADD_RD: state_in = ST_ADD_WR;
         ST_ADD_WR: begin
            state_in = ST_IDLE;
            if (req_ff.command == CMD_ADD_REF) begin
               if (ref_total_ff != CNT_MAX) ref_total_in = ref_total_ff + 1'b1;
            end else if (src_total_ff != CNT_MAX) begin
               src_total_in = src_total_ff + 1'b1;
            end
         end
         ST_BLD_GO: state_in = ST_BLD_WAIT;
         ST_BLD_WAIT: begin
            if (sts_r.build_done && sts_g.build_done && sts_b.build_done) begin
               state_in     = ST_IDLE;
               src_total_in = '0;
            end
         end
         ST_MAP_RD: state_in = ST_MAP_OUT;
         ST_MAP_OUT: begin
            state_in         = ST_IDLE;
            rsp_valid_in     = 1'b1;
            rsp_in.red_out   = blend(blend_w, sts_r.tbl_val, req_ff.red);
            rsp_in.green_out = blend(blend_w, sts_g.tbl_val, req_ff.green);
            rsp_in.blue_out  = blend(blend_w, sts_b.tbl_val, req_ff.blue);
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_ALL;
         sweep_ff     <= '0;
         ref_total_ff <= '0;
         src_total_ff <= '0;
         blend_ff     <= BLEND_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         ref_total_ff <= ref_total_in;
         src_total_ff <= src_total_in;
         blend_ff     <= blend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted map request is always followed by its result.
   a_map_latency: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.command == CMD_MAP |-> ##3 rsp_valid)
      else $error("map result missing");

   // Results last a single cycle.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A result only follows a map request.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_MAP_OUT)
      else $error("result without map request");

   // Build completion clears the source count.
   a_build_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLD_WAIT && state_in == ST_IDLE |=> src_total_ff == '0)
      else $error("source count not cleared by build");

endmodule

/* rtl/rhm_chan.sv */
// ----------------------------------------------------------------------------
// rhm_chan
// One color channel: reference bins, source bins and transfer table memories,
// plus the two-pointer walk that builds the transfer table.
// ----------------------------------------------------------------------------
module rhm_chan import rhm_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chan_ctl_type          ctl,
   input  logic [COUNT_BITS-1:0] ref_total,
   input  logic [COUNT_BITS-1:0] src_total,
   output chan_sts_type          sts
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PIX_BITS-1:0]   LAST    = {PIX_BITS{1'b1}};

   typedef enum logic [2:0] {W_IDLE, W_WAIT, W_ACC, W_MUL, W_CMP, W_FILL} walk_type;

   logic [COUNT_BITS-1:0] ref_mem [BINS];
   logic [COUNT_BITS-1:0] src_mem [BINS];
   logic [PIX_BITS-1:0]   tbl_mem [BINS];

   logic [COUNT_BITS-1:0] ref_q_ff, src_q_ff;
   logic [PIX_BITS-1:0]   tbl_q_ff;

   walk_type                state_ff, state_in;
   logic [PIX_BITS-1:0]     i_ff, i_in, j_ff, j_in;
   logic [COUNT_BITS-1:0]   sc_ff, sc_in, rc_ff, rc_in;
   logic                    adv_s_ff, adv_s_in, adv_r_ff, adv_r_in;
   logic [2*COUNT_BITS-1:0] pl_ff, pr_ff;

   logic [PIX_BITS-1:0]   ref_ra, src_ra;
   logic                  ref_we, src_we, tbl_we;
   logic [PIX_BITS-1:0]   ref_wa, src_wa, tbl_wa;
   logic [COUNT_BITS-1:0] ref_wd, src_wd;
   logic [PIX_BITS-1:0]   tbl_wd;

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [COUNT_BITS-1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   assign ref_ra = (state_ff != W_IDLE) ? j_ff : ctl.addr;
   assign src_ra = (state_ff != W_IDLE) ? i_ff : ctl.addr;

   // Memory write selection.
   always_comb begin
      ref_we = 1'b0;
      ref_wa = ctl.addr;
      ref_wd = '0;
      src_we = 1'b0;
      src_wa = ctl.addr;
      src_wd = '0;
      tbl_we = 1'b0;
      tbl_wa = ctl.addr;
      tbl_wd = '0;
      if (state_ff == W_CMP && pl_ff >= pr_ff) begin
         src_we = 1'b1;
         src_wa = i_ff;
         tbl_we = 1'b1;
         tbl_wa = i_ff;
         tbl_wd = j_ff;
      end else if (state_ff == W_FILL) begin
         src_we = 1'b1;
         src_wa = i_ff;
         tbl_we = 1'b1;
         tbl_wa = i_ff;
         tbl_wd = LAST;
      end else begin
         unique case (ctl.op)
            OP_CLR_ALL: begin
               ref_we = 1'b1;
               src_we = 1'b1;
               tbl_we = 1'b1;
            end
            OP_CLR_REF: ref_we = 1'b1;
            OP_INC_REF: begin
               ref_we = 1'b1;
               ref_wd = (ref_q_ff == CNT_MAX) ? CNT_MAX : ref_q_ff + 1'b1;
            end
            OP_INC_SRC: begin
               src_we = 1'b1;
               src_wd = (src_q_ff == CNT_MAX) ? CNT_MAX : src_q_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[ref_wa] <= ref_wd;
      ref_q_ff <= ref_mem[ref_ra];
   end

   always_ff @(posedge clock) begin
      if (src_we) src_mem[src_wa] <= src_wd;
      src_q_ff <= src_mem[src_ra];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
      tbl_q_ff <= tbl_mem[ctl.addr];
   end

   // Walk: i runs over source bins, j over reference bins; both only advance.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      sc_in    = sc_ff;
      rc_in    = rc_ff;
      adv_s_in = adv_s_ff;
      adv_r_in = adv_r_ff;
      unique case (state_ff)
         W_IDLE: if (ctl.op == OP_BUILD) begin
            state_in = W_WAIT;
            i_in     = '0;
            j_in     = '0;
            sc_in    = '0;
            rc_in    = '0;
            adv_s_in = 1'b1;
            adv_r_in = 1'b1;
         end
         W_WAIT: state_in = W_ACC;
         W_ACC: begin
            if (adv_s_ff) sc_in = sat_add(sc_ff, src_q_ff);
            if (adv_r_ff) rc_in = sat_add(rc_ff, ref_q_ff);
            state_in = W_MUL;
         end
         W_MUL: state_in = W_CMP;
         W_CMP: begin
            adv_s_in = 1'b0;
            adv_r_in = 1'b0;
            if (pl_ff >= pr_ff) begin
               if (i_ff == LAST) begin
                  state_in = W_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  adv_s_in = 1'b1;
                  state_in = W_WAIT;
               end
            end else if (j_ff == LAST) begin
               state_in = W_FILL;
            end else begin
               j_in     = j_ff + 1'b1;
               adv_r_in = 1'b1;
               state_in = W_WAIT;
            end
         end
         W_FILL: begin
            if (i_ff == LAST) state_in = W_IDLE;
            else i_in = i_ff + 1'b1;
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      sc_ff    <= sc_in;
      rc_ff    <= rc_in;
      adv_s_ff <= adv_s_in;
      adv_r_ff <= adv_r_in;
      pl_ff    <= (2*COUNT_BITS)'(rc_ff) * (2*COUNT_BITS)'(src_total);
      pr_ff    <= (2*COUNT_BITS)'(sc_ff) * (2*COUNT_BITS)'(ref_total);
   end

   assign sts.build_done = (state_ff == W_IDLE);
   assign sts.tbl_val    = tbl_q_ff;

endmodule
